### src/icv6rv_pkg.sv
package icv6rv_pkg;

    // Default size of the Bloom bit store, as a power of two of its bit count.
    localparam int unsigned BLOOM_INDEX_BITS_DEF = 20;

    // The store is organised as 32-bit rows; the low hash bits pick the bit in a row.
    localparam int unsigned ROW_WIDTH    = 32;
    localparam int unsigned BIT_SEL_BITS = 5;

    // Header values that a valid reply carries.
    localparam logic [15:0] ETHER_TYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  NEXT_HDR_ICMPV6 = 8'd58;
    localparam logic [7:0]  ICMP_KIND_REPLY = 8'd154;
    localparam logic [7:0]  ICMP_SUBCODE_OK = 8'd3;

    // Seed values after reset.
    localparam logic [31:0] CHECKSUM_SEED_RST = 32'h11112222;
    localparam logic [31:0] BLOOM_SEED1_RST   = 32'h12345678;
    localparam logic [31:0] BLOOM_SEED2_RST   = 32'h87654321;

    // Mixing constants of the 32-bit hash.
    localparam logic [31:0] MM_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2  = 32'h1b873593;
    localparam logic [31:0] MM_N   = 32'he6546b64;
    localparam logic [31:0] MM_F1  = 32'h85ebca6b;
    localparam logic [31:0] MM_F2  = 32'hc2b2ae35;

    // Byte lengths hashed: twelve address bytes for the checksum, all sixteen for the filter.
    localparam logic [31:0] CKS_LEN   = 32'd12;
    localparam logic [31:0] BLOOM_LEN = 32'd16;
    localparam logic [1:0]  CKS_LAST_BLK   = 2'd2;
    localparam logic [1:0]  BLOOM_LAST_BLK = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_CHECKSUM_SEED = 2'd0;
    localparam logic [1:0] REG_BLOOM_SEED1   = 2'd1;
    localparam logic [1:0] REG_BLOOM_SEED2   = 2'd2;

    typedef enum logic [2:0] {
        ST_ACCEPT   = 3'd0,
        ST_NOT_IPV6 = 3'd1,
        ST_NOT_ICMP = 3'd2,
        ST_BAD_TYPE = 3'd3,
        ST_BAD_CKS  = 3'd4,
        ST_DUP      = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        HOP_NONE,
        HOP_INIT,
        HOP_K1,
        HOP_K2,
        HOP_MIX,
        HOP_F1,
        HOP_F2,
        HOP_F3
    } t_hop;

    typedef enum logic [1:0] {
        HS_CKS,
        HS_FIRST,
        HS_SECOND
    } t_hsel;

    typedef enum logic [1:0] {
        MOP_NONE,
        MOP_CLEAR,
        MOP_READ,
        MOP_WRITE
    } t_mop;

    typedef struct packed {
        logic       load;
        t_hop       hop;
        t_hsel      hsel;
        logic [1:0] blk;
        logic       save_h1;
        logic       save_h2;
        t_mop       mop;
        logic       msel;
        logic       cap1;
        logic       emit;
        t_status    code;
    } t_cmd;

    typedef struct packed {
        t_status hdr_code;
        logic    cks_ok;
        logic    dup;
        logic    clr_last;
    } t_stat;

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

### src/icv6rv_dp.sv
module icv6rv_dp #(
    parameter int unsigned BLOOM_INDEX_BITS = icv6rv_pkg::BLOOM_INDEX_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  icv6rv_pkg::t_cmd   i_cmd,
    output icv6rv_pkg::t_stat  o_stat,
    input  logic [31:0]        i_checksum_seed,
    input  logic [31:0]        i_bloom_seed_first,
    input  logic [31:0]        i_bloom_seed_second,
    input  logic [15:0]        i_ether_type,
    input  logic [7:0]         i_next_header,
    input  logic [7:0]         i_icmp_kind,
    input  logic [7:0]         i_icmp_subcode,
    input  logic [63:0]        i_source_high,
    input  logic [63:0]        i_source_low,
    input  logic [15:0]        i_identifier,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic [7:0]         o_prefix_id,
    output logic [63:0]        o_target_high,
    output logic [63:0]        o_target_low
);
    import icv6rv_pkg::*;

    localparam int unsigned ROW_BITS = BLOOM_INDEX_BITS - BIT_SEL_BITS;
    localparam int unsigned ROWS     = 2 ** ROW_BITS;

    logic [15:0] r_ether_type;
    logic [7:0]  r_next_header;
    logic [7:0]  r_icmp_kind;
    logic [7:0]  r_icmp_subcode;
    logic [63:0] r_src_hi;
    logic [63:0] r_src_lo;
    logic [15:0] r_identifier;

    logic [31:0] r_h, n_h;
    logic [31:0] r_k, n_k;
    logic [31:0] r_h1;
    logic [31:0] r_h2;
    logic        r_bit1;
    logic [31:0] r_rd_data;
    logic [ROW_BITS-1:0] r_clr_cnt;
    logic [ROW_WIDTH-1:0] r_mem [0:ROWS-1];

    logic        r_done;
    logic [2:0]  r_status;
    logic [7:0]  r_prefix;
    logic [63:0] r_tgt_hi;
    logic [63:0] r_tgt_lo;

    logic [31:0] w_word;
    logic [31:0] w_seed;
    logic [31:0] w_len;
    logic [31:0] w_krot;
    logic [31:0] w_mx;
    logic [31:0] w_mrot;
    logic [31:0] w_f1a;
    logic [31:0] w_f1;
    logic [31:0] w_f2;
    logic [31:0] w_msel_h;
    logic [ROW_BITS-1:0]     w_row;
    logic [BIT_SEL_BITS-1:0] w_bit;
    t_status     w_hdr;
    logic        w_keep_prefix;
    logic        w_keep_target;

    always_comb begin
        case (i_cmd.blk)
            2'd0:    w_word = bswap32(r_src_hi[63:32]);
            2'd1:    w_word = bswap32(r_src_hi[31:0]);
            2'd2:    w_word = bswap32(r_src_lo[63:32]);
            default: w_word = bswap32(r_src_lo[31:0]);
        endcase
        case (i_cmd.hsel)
            HS_CKS:   w_seed = i_checksum_seed;
            HS_FIRST: w_seed = i_bloom_seed_first;
            default:  w_seed = i_bloom_seed_second;
        endcase
        w_len = (i_cmd.hsel == HS_CKS) ? CKS_LEN : BLOOM_LEN;
    end

    assign w_krot = {r_k[16:0], r_k[31:17]};
    assign w_mx   = r_h ^ r_k;
    assign w_mrot = {w_mx[18:0], w_mx[31:19]};
    assign w_f1a  = r_h ^ w_len;
    assign w_f1   = w_f1a ^ {16'd0, w_f1a[31:16]};
    assign w_f2   = r_h ^ {13'd0, r_h[31:13]};

    always_comb begin
        n_h = r_h;
        n_k = r_k;
        case (i_cmd.hop)
            HOP_INIT: n_h = w_seed;
            HOP_K1:   n_k = w_word * MM_C1;
            HOP_K2:   n_k = w_krot * MM_C2;
            HOP_MIX:  n_h = {w_mrot[29:0], 2'b00} + w_mrot + MM_N;
            HOP_F1:   n_h = w_f1 * MM_F1;
            HOP_F2:   n_h = w_f2 * MM_F2;
            HOP_F3:   n_h = r_h ^ {16'd0, r_h[31:16]};
            default:  n_h = r_h;
        endcase
    end

    always_comb begin
        if (r_ether_type != ETHER_TYPE_IPV6) begin
            w_hdr = ST_NOT_IPV6;
        end else if (r_next_header != NEXT_HDR_ICMPV6) begin
            w_hdr = ST_NOT_ICMP;
        end else if (r_icmp_kind != ICMP_KIND_REPLY || r_icmp_subcode != ICMP_SUBCODE_OK) begin
            w_hdr = ST_BAD_TYPE;
        end else begin
            w_hdr = ST_ACCEPT;
        end
    end

    assign w_msel_h = i_cmd.msel ? r_h2 : r_h1;
    assign w_row    = w_msel_h[BLOOM_INDEX_BITS-1:BIT_SEL_BITS];
    assign w_bit    = w_msel_h[BIT_SEL_BITS-1:0];

    assign o_stat.hdr_code = w_hdr;
    assign o_stat.cks_ok   = (r_h == r_src_lo[31:0]);
    assign o_stat.dup      = r_bit1 & r_rd_data[r_h2[BIT_SEL_BITS-1:0]];
    assign o_stat.clr_last = &r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ether_type   <= i_ether_type;
            r_next_header  <= i_next_header;
            r_icmp_kind    <= i_icmp_kind;
            r_icmp_subcode <= i_icmp_subcode;
            r_src_hi       <= i_source_high;
            r_src_lo       <= i_source_low;
            r_identifier   <= i_identifier;
        end
        r_h <= n_h;
        r_k <= n_k;
        if (i_cmd.save_h1) begin
            r_h1 <= r_h;
        end
        if (i_cmd.save_h2) begin
            r_h2 <= r_h;
        end
        if (i_cmd.cap1) begin
            r_bit1 <= r_rd_data[r_h1[BIT_SEL_BITS-1:0]];
        end
    end

    // Single-port bit store: one row written or read per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mop == MOP_CLEAR) begin
            r_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.mop == MOP_WRITE) begin
            r_mem[w_row] <= r_rd_data | (32'd1 << w_bit);
        end
        if (i_cmd.mop == MOP_READ) begin
            r_rd_data <= r_mem[w_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.mop == MOP_CLEAR) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    assign w_keep_prefix = (i_cmd.code == ST_ACCEPT) || (i_cmd.code == ST_DUP);
    assign w_keep_target = w_keep_prefix || (i_cmd.code == ST_BAD_CKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
        if (i_cmd.emit) begin
            r_status <= i_cmd.code;
            r_prefix <= w_keep_prefix ? r_identifier[15:8] : 8'd0;
            r_tgt_hi <= w_keep_target ? r_src_hi : 64'd0;
            r_tgt_lo <= w_keep_target ? r_src_lo : 64'd0;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_prefix_id    = r_prefix;
    assign o_target_high  = r_tgt_hi;
    assign o_target_low   = r_tgt_lo;

endmodule

### src/icv6rv_ctrl.sv
module icv6rv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  icv6rv_pkg::t_stat i_stat,
    output icv6rv_pkg::t_cmd  o_cmd,
    output logic              o_busy
);
    import icv6rv_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_HDR,
        S_INIT,
        S_K1,
        S_K2,
        S_MIX,
        S_F1,
        S_F2,
        S_F3,
        S_END,
        S_RD1,
        S_RD2,
        S_RD3,
        S_SET1,
        S_SET1W,
        S_SET2,
        S_SET2W
    } t_state;

    t_state     r_state, n_state;
    t_hsel      r_hsel, n_hsel;
    logic [1:0] r_blk, n_blk;
    logic [1:0] w_last_blk;

    assign w_last_blk = (r_hsel == HS_CKS) ? CKS_LAST_BLK : BLOOM_LAST_BLK;

    always_comb begin
        n_state = r_state;
        n_hsel  = r_hsel;
        n_blk   = r_blk;
        o_cmd   = '{load: 1'b0, hop: HOP_NONE, hsel: r_hsel, blk: r_blk,
                    save_h1: 1'b0, save_h2: 1'b0, mop: MOP_NONE, msel: 1'b0,
                    cap1: 1'b0, emit: 1'b0, code: ST_ACCEPT};
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.mop = MOP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = i_start;
                if (i_start) begin
                    n_state = S_HDR;
                end
            end
            S_HDR: begin
                if (i_stat.hdr_code != ST_ACCEPT) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = i_stat.hdr_code;
                    n_state    = S_IDLE;
                end else begin
                    n_hsel  = HS_CKS;
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.hop = HOP_INIT;
                n_blk     = 2'd0;
                n_state   = S_K1;
            end
            S_K1: begin
                o_cmd.hop = HOP_K1;
                n_state   = S_K2;
            end
            S_K2: begin
                o_cmd.hop = HOP_K2;
                n_state   = S_MIX;
            end
            S_MIX: begin
                o_cmd.hop = HOP_MIX;
                n_blk     = r_blk + 2'd1;
                n_state   = (r_blk == w_last_blk) ? S_F1 : S_K1;
            end
            S_F1: begin
                o_cmd.hop = HOP_F1;
                n_state   = S_F2;
            end
            S_F2: begin
                o_cmd.hop = HOP_F2;
                n_state   = S_F3;
            end
            S_F3: begin
                o_cmd.hop = HOP_F3;
                n_state   = S_END;
            end
            S_END: begin
                unique case (r_hsel)
                    HS_CKS: begin
                        if (i_stat.cks_ok) begin
                            n_hsel  = HS_FIRST;
                            n_state = S_INIT;
                        end else begin
                            o_cmd.emit = 1'b1;
                            o_cmd.code = ST_BAD_CKS;
                            n_state    = S_IDLE;
                        end
                    end
                    HS_FIRST: begin
                        o_cmd.save_h1 = 1'b1;
                        n_hsel        = HS_SECOND;
                        n_state       = S_INIT;
                    end
                    default: begin
                        o_cmd.save_h2 = 1'b1;
                        n_state       = S_RD1;
                    end
                endcase
            end
            S_RD1: begin
                o_cmd.mop  = MOP_READ;
                o_cmd.msel = 1'b0;
                n_state    = S_RD2;
            end
            S_RD2: begin
                o_cmd.mop  = MOP_READ;
                o_cmd.msel = 1'b1;
                o_cmd.cap1 = 1'b1;
                n_state    = S_RD3;
            end
            S_RD3: begin
                if (i_stat.dup) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = ST_DUP;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_SET1;
                end
            end
            S_SET1: begin
                o_cmd.mop  = MOP_READ;
                o_cmd.msel = 1'b0;
                n_state    = S_SET1W;
            end
            S_SET1W: begin
                o_cmd.mop  = MOP_WRITE;
                o_cmd.msel = 1'b0;
                n_state    = S_SET2;
            end
            S_SET2: begin
                o_cmd.mop  = MOP_READ;
                o_cmd.msel = 1'b1;
                n_state    = S_SET2W;
            end
            S_SET2W: begin
                o_cmd.mop  = MOP_WRITE;
                o_cmd.msel = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.code = ST_ACCEPT;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_hsel  <= HS_CKS;
            r_blk   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_hsel  <= n_hsel;
            r_blk   <= n_blk;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### src/icmpv6_reply_validate_dedup.sv
// ICMPv6 reply validator with duplicate suppression.
// A packet's header fields are offered on the i_ ports and taken as one beat
// at a clock edge where start is high and busy is low. Exactly one result beat
// follows, shown for a single cycle with o_done high; the receiver cannot hold
// it off, so it must take it in that cycle.
// An early rejection (EtherType, next header, type/code) comes from the header
// check, a checksum mismatch after the checksum hash, a duplicate after both
// Bloom hashes and the bit reads, and an accepted packet after the two bit
// updates as well. The three hashes run in turn, each a seed load, per block
// a key multiply, a rotate and multiply and a mix, then finalisation and a
// check; the single-port bit store needs two reads and two read-modify-write
// updates. A new packet can be taken in the cycle that shows the last result.
// After reset the Bloom bit store is swept clear one 32-bit row per cycle,
// 2**(BLOOM_INDEX_BITS-5) rows (32768 at the default); busy stays high until
// the sweep ends. The seeds return to their defaults at reset and may be
// written over the APB port while the block is idle.
module icmpv6_reply_validate_dedup #(
    parameter int unsigned BLOOM_INDEX_BITS = icv6rv_pkg::BLOOM_INDEX_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_next_header,
    input  logic [7:0]  i_icmp_kind,
    input  logic [7:0]  i_icmp_subcode,
    input  logic [63:0] i_source_high,
    input  logic [63:0] i_source_low,
    input  logic [15:0] i_identifier,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [7:0]  o_prefix_id,
    output logic [63:0] o_target_high,
    output logic [63:0] o_target_low,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import icv6rv_pkg::*;

    t_cmd        w_cmd;
    t_stat       w_stat;
    logic        w_wr;
    logic [31:0] r_checksum_seed;
    logic [31:0] r_bloom_seed1;
    logic [31:0] r_bloom_seed2;

    // The configuration registers sit at word addresses; writes beyond the last
    // register are dropped.
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_checksum_seed <= CHECKSUM_SEED_RST;
            r_bloom_seed1   <= BLOOM_SEED1_RST;
            r_bloom_seed2   <= BLOOM_SEED2_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_CHECKSUM_SEED: r_checksum_seed <= pwdata;
                REG_BLOOM_SEED1:   r_bloom_seed1   <= pwdata;
                REG_BLOOM_SEED2:   r_bloom_seed2   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CHECKSUM_SEED: prdata = r_checksum_seed;
            REG_BLOOM_SEED1:   prdata = r_bloom_seed1;
            REG_BLOOM_SEED2:   prdata = r_bloom_seed2;
            default:           prdata = 32'd0;
        endcase
    end

    icv6rv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    icv6rv_dp #(
        .BLOOM_INDEX_BITS (BLOOM_INDEX_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_checksum_seed     (r_checksum_seed),
        .i_bloom_seed_first  (r_bloom_seed1),
        .i_bloom_seed_second (r_bloom_seed2),
        .i_ether_type        (i_ether_type),
        .i_next_header       (i_next_header),
        .i_icmp_kind         (i_icmp_kind),
        .i_icmp_subcode      (i_icmp_subcode),
        .i_source_high       (i_source_high),
        .i_source_low        (i_source_low),
        .i_identifier        (i_identifier),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_prefix_id         (o_prefix_id),
        .o_target_high       (o_target_high),
        .o_target_low        (o_target_low)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

// Self-checking testbench for icmpv6_reply_validate_dedup.
// A queue of packet beats, filled by the stimulus process, feeds a clocked
// driver that offers one beat at a time on the command interface. A clocked
// monitor predicts the result of each accepted beat with its own copy of the
// hash, the seeds and the Bloom store, and compares every result beat, field
// by field, with the oldest prediction.
module testbench;
    import icv6rv_pkg::*;

    localparam int unsigned INDEX_BITS = BLOOM_INDEX_BITS_DEF;
    localparam int unsigned MAP_DEPTH  = 1 << INDEX_BITS;
    // Register index beyond the last seed; writes there must have no effect.
    localparam logic [1:0]  REG_UNUSED = 2'd3;
    // Cycles without any accepted beat or result beat before the run is abandoned. This has
    // to cover the store sweep after reset as well as the slowest packet.
    localparam int unsigned STALL_LIMIT = 200000;
    // Quiet time that covers the longest packet latency.
    localparam int unsigned DRAIN_CYCLES = 80;

    typedef struct {
        logic [15:0] ether_type;
        logic [7:0]  next_header;
        logic [7:0]  icmp_kind;
        logic [7:0]  icmp_subcode;
        logic [63:0] source_high;
        logic [63:0] source_low;
        logic [15:0] identifier;
    } t_packet;

    typedef struct {
        t_status     status;
        logic [7:0]  prefix_id;
        logic [63:0] target_high;
        logic [63:0] target_low;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_ether_type;
    logic [7:0]  i_next_header;
    logic [7:0]  i_icmp_kind;
    logic [7:0]  i_icmp_subcode;
    logic [63:0] i_source_high;
    logic [63:0] i_source_low;
    logic [15:0] i_identifier;
    logic        o_done;
    logic [2:0]  o_status;
    logic [7:0]  o_prefix_id;
    logic [63:0] o_target_high;
    logic [63:0] o_target_low;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    icmpv6_reply_validate_dedup DUT (.*);

    // Stimulus, predictions and bookkeeping.
    t_packet     pending_packets[$];
    t_verdict    expected_verdicts[$];
    logic [127:0] known_sources[$];
    bit          seen_map [0:MAP_DEPTH-1];
    logic [31:0] cks_seed;
    logic [31:0] seed_first;
    logic [31:0] seed_second;
    int unsigned sender_idle_pct;
    int unsigned queued_count;
    int unsigned taken_count;
    int unsigned quiet_cycles;
    int unsigned error_count;
    bit          beat_taken;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // 32-bit MurmurHash3 over the first nblocks four-byte blocks of a
    // big-endian address; each block is read little-endian.
    function automatic logic [31:0] murmur32(input logic [127:0] addr,
                                             input int nblocks,
                                             input logic [31:0] seed);
        logic [31:0] h;
        logic [31:0] k;
        logic [7:0]  b [0:3];
        h = seed;
        for (int i = 0; i < nblocks; i++) begin
            for (int j = 0; j < 4; j++)
                b[j] = addr[127 - 8*(4*i + j) -: 8];
            k = {b[3], b[2], b[1], b[0]};
            k = k * 32'hcc9e2d51;
            k = {k[16:0], k[31:17]};
            k = k * 32'h1b873593;
            h = h ^ k;
            h = {h[18:0], h[31:19]};
            h = h * 32'd5 + 32'he6546b64;
        end
        h = h ^ (nblocks * 4);
        h = h ^ (h >> 16);
        h = h * 32'h85ebca6b;
        h = h ^ (h >> 13);
        h = h * 32'hc2b2ae35;
        h = h ^ (h >> 16);
        return h;
    endfunction

    // Works out the verdict of one packet and updates the Bloom store copy.
    function automatic t_verdict judge_packet(input t_packet p);
        t_verdict    v;
        logic [127:0] addr;
        logic [31:0] h1;
        logic [31:0] h2;
        v = '{ST_ACCEPT, 8'd0, 64'd0, 64'd0};
        addr = {p.source_high, p.source_low};
        if (p.ether_type != ETHER_TYPE_IPV6) begin
            v.status = ST_NOT_IPV6;
        end else if (p.next_header != NEXT_HDR_ICMPV6) begin
            v.status = ST_NOT_ICMP;
        end else if (p.icmp_kind != ICMP_KIND_REPLY || p.icmp_subcode != ICMP_SUBCODE_OK) begin
            v.status = ST_BAD_TYPE;
        end else begin
            v.target_high = p.source_high;
            v.target_low  = p.source_low;
            if (p.source_low[31:0] != murmur32(addr, 3, cks_seed)) begin
                v.status = ST_BAD_CKS;
            end else begin
                v.prefix_id = p.identifier[15:8];
                h1 = murmur32(addr, 4, seed_first);
                h2 = murmur32(addr, 4, seed_second);
                if (seen_map[h1[INDEX_BITS-1:0]] && seen_map[h2[INDEX_BITS-1:0]]) begin
                    v.status = ST_DUP;
                end else begin
                    seen_map[h1[INDEX_BITS-1:0]] = 1'b1;
                    seen_map[h2[INDEX_BITS-1:0]] = 1'b1;
                end
            end
        end
        return v;
    endfunction

    // Builds a well-formed reply whose embedded checksum matches the seed in
    // force; a set corrupt flag flips one checksum bit instead.
    function automatic t_packet make_reply(input logic [95:0] prefix,
                                           input logic [15:0] ident,
                                           input bit corrupt);
        t_packet     p;
        logic [31:0] cks;
        cks = murmur32({prefix, 32'd0}, 3, cks_seed);
        if (corrupt)
            cks[$urandom_range(31)] ^= 1'b1;
        p.ether_type   = ETHER_TYPE_IPV6;
        p.next_header  = NEXT_HDR_ICMPV6;
        p.icmp_kind    = ICMP_KIND_REPLY;
        p.icmp_subcode = ICMP_SUBCODE_OK;
        {p.source_high, p.source_low} = {prefix, cks};
        p.identifier   = ident;
        return p;
    endfunction

    function automatic logic [95:0] rand_prefix();
        return {$urandom, $urandom, $urandom};
    endfunction

    function automatic t_packet rand_noise();
        t_packet p;
        p = make_reply(rand_prefix(), 16'($urandom), 1'b0);
        case ($urandom_range(3))
            0: p.ether_type = 16'($urandom);
            1: p.next_header = 8'($urandom);
            2: p.icmp_kind = 8'($urandom);
            default: p.icmp_subcode = 8'($urandom);
        endcase
        if ($urandom_range(1)) begin
            p.source_high = {$urandom, $urandom};
            p.source_low  = {$urandom, $urandom};
        end
        return p;
    endfunction

    task automatic queue_packet(input t_packet p);
        pending_packets.push_back(p);
        queued_count++;
        if (p.ether_type == ETHER_TYPE_IPV6 && p.next_header == NEXT_HDR_ICMPV6)
            known_sources.push_back({p.source_high, p.source_low});
    endtask

    // A mixed batch: mostly valid replies, with repeats of earlier sources
    // to provoke duplicates, some corrupt checksums and some header noise.
    task automatic queue_random(input int count);
        t_packet      p;
        int unsigned  pick;
        logic [127:0] src;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                p = make_reply(rand_prefix(), 16'($urandom), 1'b0);
            end else if (pick < 70 && known_sources.size() > 0) begin
                src = known_sources[$urandom_range(known_sources.size() - 1)];
                p = make_reply(src[127:32], 16'($urandom), 1'b0);
            end else if (pick < 82) begin
                p = make_reply(rand_prefix(), 16'($urandom), 1'b1);
            end else begin
                p = rand_noise();
            end
            queue_packet(p);
        end
    endtask

    // Seeds are written only while the block is idle.
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_CHECKSUM_SEED: cks_seed = value;
            REG_BLOOM_SEED1:   seed_first = value;
            REG_BLOOM_SEED2:   seed_second = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (taken_count == queued_count && expected_verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Driver: a beat is held until taken, then the next one is offered or
    // the sender idles.
    always @(negedge i_clk) begin
        t_packet p;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || beat_taken) begin
            if (pending_packets.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                p = pending_packets.pop_front();
                i_ether_type   <= p.ether_type;
                i_next_header  <= p.next_header;
                i_icmp_kind    <= p.icmp_kind;
                i_icmp_subcode <= p.icmp_subcode;
                i_source_high  <= p.source_high;
                i_source_low   <= p.source_low;
                i_identifier   <= p.identifier;
                start          <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks result beats, predicts accepted packets and watches
    // for a stalled run.
    always @(posedge i_clk) begin
        t_verdict want;
        t_packet  p;
        beat_taken = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_verdicts.size() == 0) begin
                    $error("result beat with no packet outstanding, status %0d", o_status);
                    error_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_prefix_id !== want.prefix_id) begin
                        $error("prefix_id: expected %0h, got %0h",
                               want.prefix_id, o_prefix_id);
                        error_count++;
                    end
                    if (o_target_high !== want.target_high) begin
                        $error("target_high: expected %0h, got %0h",
                               want.target_high, o_target_high);
                        error_count++;
                    end
                    if (o_target_low !== want.target_low) begin
                        $error("target_low: expected %0h, got %0h",
                               want.target_low, o_target_low);
                        error_count++;
                    end
                end
            end
            if (start && !busy) begin
                p = '{i_ether_type, i_next_header, i_icmp_kind, i_icmp_subcode,
                      i_source_high, i_source_low, i_identifier};
                expected_verdicts.push_back(judge_packet(p));
                taken_count++;
                beat_taken = 1'b1;
            end
            quiet_cycles = (o_done || beat_taken) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        t_packet p;
        start = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_ether_type = '0;
        i_next_header = '0;
        i_icmp_kind = '0;
        i_icmp_subcode = '0;
        i_source_high = '0;
        i_source_low = '0;
        i_identifier = '0;
        queued_count = 0;
        taken_count = 0;
        quiet_cycles = 0;
        error_count = 0;
        beat_taken = 1'b0;
        sender_idle_pct = 0;
        for (int i = 0; i < MAP_DEPTH; i++)
            seen_map[i] = 1'b0;
        cks_seed = CHECKSUM_SEED_RST;
        seed_first = BLOOM_SEED1_RST;
        seed_second = BLOOM_SEED2_RST;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed beats under the reset seeds: each early rejection at
        // field extremes, a checksum mismatch, and first sightings and
        // repeats of the all-zero and all-ones prefixes and of six random prefixes.
        p = make_reply('0, 16'h0000, 1'b0);
        p.ether_type = 16'h0000;
        queue_packet(p);
        p.ether_type = 16'hFFFF;
        queue_packet(p);
        p = make_reply('1, 16'hFFFF, 1'b0);
        p.next_header = 8'h00;
        queue_packet(p);
        p.next_header = 8'hFF;
        queue_packet(p);
        p = make_reply('1, 16'hFFFF, 1'b0);
        p.icmp_kind = 8'hFF;
        queue_packet(p);
        p = make_reply('1, 16'hFFFF, 1'b0);
        p.icmp_subcode = 8'h00;
        queue_packet(p);
        p.icmp_kind = 8'h00;
        p.icmp_subcode = 8'hFF;
        queue_packet(p);
        queue_packet(make_reply('1, 16'hA5A5, 1'b1));
        queue_packet(make_reply('0, 16'h0000, 1'b0));
        queue_packet(make_reply('1, 16'hFFFF, 1'b0));
        queue_packet(make_reply('0, 16'hFF00, 1'b0));
        queue_packet(make_reply('1, 16'h00FF, 1'b0));
        for (int i = 0; i < 6; i++) begin
            p = make_reply(rand_prefix(), 16'($urandom), 1'b0);
            queue_packet(p);
            queue_packet(p);
        end
        drain();

        // Zero checksum and first Bloom seeds, all-ones second; sender idle about 1/4 of the time.
        // The write to the unused index must leave every seed alone.
        write_reg(REG_CHECKSUM_SEED, 32'h0000_0000);
        write_reg(REG_BLOOM_SEED1, 32'h0000_0000);
        write_reg(REG_BLOOM_SEED2, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        sender_idle_pct = 24;
        queue_random(360);
        drain();

        // All-ones checksum and first Bloom seeds and a zero second seed, with a mostly idle sender.
        write_reg(REG_CHECKSUM_SEED, 32'hFFFF_FFFF);
        write_reg(REG_BLOOM_SEED1, 32'hFFFF_FFFF);
        write_reg(REG_BLOOM_SEED2, 32'h0000_0000);
        sender_idle_pct = 78;
        queue_random(360);
        drain();

        // Equal Bloom seeds make both hashes pick the same bit; back to back.
        write_reg(REG_CHECKSUM_SEED, $urandom);
        write_reg(REG_BLOOM_SEED1, 32'h5A5A_0F0F);
        write_reg(REG_BLOOM_SEED2, 32'h5A5A_0F0F);
        write_reg(REG_UNUSED, 32'h0000_0000);
        sender_idle_pct = 0;
        queue_random(360);
        drain();

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
